/* src/rau_pkg.sv */
package rau_pkg;

  localparam int unsigned RAU_OPERAND_WIDTH = 16;
  localparam int unsigned CMD_W = 3;
  localparam int unsigned NUM_W = 33;
  localparam int unsigned DEN_W = 31;

  localparam logic [CMD_W-1:0] CMD_REDUCE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_MAX    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ADD    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SUB    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_MUL    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DIV    = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_PREP,
    S_WAIT,
    S_DONE
  } seq_state_e;

  typedef enum logic [2:0] {
    I_IDLE,
    I_GCD,
    I_DIVN,
    I_DIVD,
    I_DONE
  } iter_state_e;

endpackage

/* src/rau_iter.sv */
module rau_iter #(
  parameter int unsigned PW = 33
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [PW-1:0] n_i,
  input  logic [PW-1:0] d_i,
  output logic          done_o,
  output logic [PW-1:0] qn_o,
  output logic [PW-1:0] qd_o
);
  import rau_pkg::*;

  localparam int unsigned CW = $clog2(PW + 1);

  iter_state_e state_q, state_d;

  logic [PW-1:0] u_q, v_q, g_q, nsv_q, dsv_q, rem_q, quo_q, qn_q;
  logic [CW-1:0] k_q, cnt_q;
  logic [PW:0]   trial;
  logic [PW:0]   diff;
  logic          take;
  logic          gcd_end;
  logic          div_last;

  assign trial    = {rem_q, quo_q[PW-1]};
  assign diff     = trial - {1'b0, g_q};
  assign take     = !diff[PW];
  assign gcd_end  = (u_q == '0) || (v_q == '0);
  assign div_last = (cnt_q == CW'(PW - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      I_IDLE:  if (start_i) state_d = I_GCD;
      I_GCD:   if (gcd_end) state_d = I_DIVN;
      I_DIVN:  if (div_last) state_d = I_DIVD;
      I_DIVD:  if (div_last) state_d = I_DONE;
      I_DONE:  state_d = I_IDLE;
      default: state_d = I_IDLE;
    endcase
  end

  always_comb begin
    done_o = 1'b0;
    case (state_q)
      I_DONE:  done_o = 1'b1;
      default: done_o = 1'b0;
    endcase
  end

  assign qn_o = qn_q;
  assign qd_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= I_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      I_IDLE: begin
        u_q   <= n_i;
        v_q   <= d_i;
        nsv_q <= n_i;
        dsv_q <= d_i;
        k_q   <= '0;
      end
      I_GCD: begin
        if (gcd_end) begin
          g_q   <= (u_q == '0) ? (v_q << k_q) : (u_q << k_q);
          rem_q <= '0;
          quo_q <= nsv_q;
          cnt_q <= '0;
        end else if (!u_q[0] && !v_q[0]) begin
          u_q <= u_q >> 1;
          v_q <= v_q >> 1;
          k_q <= k_q + 1'b1;
        end else if (!u_q[0]) begin
          u_q <= u_q >> 1;
        end else if (!v_q[0]) begin
          v_q <= v_q >> 1;
        end else if (u_q >= v_q) begin
          u_q <= u_q - v_q;
        end else begin
          v_q <= v_q - u_q;
        end
      end
      I_DIVN, I_DIVD: begin
        if (div_last && state_q == I_DIVN) begin
          qn_q  <= {quo_q[PW-2:0], take};
          rem_q <= '0;
          quo_q <= dsv_q;
          cnt_q <= '0;
        end else begin
          rem_q <= take ? diff[PW-1:0] : trial[PW-1:0];
          quo_q <= {quo_q[PW-2:0], take};
          cnt_q <= cnt_q + 1'b1;
        end
      end
      default: begin
        k_q <= k_q;
      end
    endcase
  end

endmodule

/* src/rational_arithmetic_unit.sv */
// Rational arithmetic unit: pulse start_i while busy_o is low to hand in a command and two
// signed fractions; busy_o stays high until the reduced result has been shown. The result
// appears for exactly one cycle with valid_o high and is not held, so the receiver must
// take it in that cycle. A command with a zero denominator or a zero result numerator goes
// through four products on the shared multiplier, one state to form the fraction and one to
// show it. Any other command computes the same four products on the shared multiplier, then
// a binary gcd on the shift/subtract unit (one step a cycle) and two bit-serial divisions
// by the gcd, one quotient bit a cycle, before the reduced result is shown.
module rational_arithmetic_unit #(
  parameter int unsigned OPERAND_WIDTH = rau_pkg::RAU_OPERAND_WIDTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic [rau_pkg::CMD_W-1:0]            cmd_i,
  input  logic signed [OPERAND_WIDTH-1:0]      a_num_i,
  input  logic signed [OPERAND_WIDTH-1:0]      a_den_i,
  input  logic signed [OPERAND_WIDTH-1:0]      b_num_i,
  input  logic signed [OPERAND_WIDTH-1:0]      b_den_i,
  output logic                                 valid_o,
  output logic signed [rau_pkg::NUM_W-1:0]     res_num_o,
  output logic [rau_pkg::DEN_W-1:0]            res_den_o,
  output logic                                 zero_den_error_o
);
  import rau_pkg::*;

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned MW = 2 * W;
  localparam int unsigned PW = 2 * W + 1;
  localparam int unsigned XW = (PW > NUM_W) ? PW : NUM_W;

  seq_state_e state_q, state_d;

  logic [CMD_W-1:0] cmd_q;
  logic [W-1:0]     an_q, ad_q, bn_q, bd_q;
  logic             ans_q, ads_q, bns_q, bds_q;
  logic [MW-1:0]    xm_q, ym_q, pd_q, pn_q;
  logic [W-1:0]     mul_a, mul_b;
  logic [MW-1:0]    prod;
  logic             accept;
  logic             iter_go;
  logic             iter_done;
  logic [PW-1:0]    qn, qd;

  logic             sa, sb, is_red, err, yneg, gt;
  logic [PW-1:0]    rn, rd;
  logic             rneg;
  logic             neg_q;
  logic [NUM_W-1:0] res_num_q;
  logic [DEN_W-1:0] res_den_q;
  logic             err_q;
  logic [XW-1:0]    ext_n, ext_d;

  function automatic logic [W-1:0] mag(input logic [W-1:0] x);
    mag = x[W-1] ? (~x + 1'b1) : x;
  endfunction

  assign accept = start_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (start_i) state_d = S_MUL0;
      S_MUL0:  state_d = S_MUL1;
      S_MUL1:  state_d = S_MUL2;
      S_MUL2:  state_d = S_MUL3;
      S_MUL3:  state_d = S_PREP;
      S_PREP:  state_d = (err || rn == '0) ? S_DONE : S_WAIT;
      S_WAIT:  if (iter_done) state_d = S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    busy_o  = 1'b1;
    valid_o = 1'b0;
    iter_go = 1'b0;
    mul_a   = an_q;
    mul_b   = bd_q;
    case (state_q)
      S_IDLE: busy_o = 1'b0;
      S_MUL1: begin
        mul_a = bn_q;
        mul_b = ad_q;
      end
      S_MUL2: begin
        mul_a = ad_q;
        mul_b = bd_q;
      end
      S_MUL3: begin
        mul_a = an_q;
        mul_b = bn_q;
      end
      S_PREP: iter_go = !(err || rn == '0);
      S_DONE: valid_o = 1'b1;
      default: busy_o = 1'b1;
    endcase
  end

  assign prod = MW'(mul_a) * MW'(mul_b);

  always_comb begin
    sa     = (ans_q != ads_q) && (an_q != '0);
    sb     = (bns_q != bds_q) && (bn_q != '0);
    is_red = (cmd_q == CMD_REDUCE) || (cmd_q > CMD_DIV);
    if (is_red) begin
      err = (ad_q == '0);
    end else begin
      err = (ad_q == '0) || (bd_q == '0) || ((cmd_q == CMD_DIV) && (bn_q == '0));
    end
    yneg = sb ^ (cmd_q == CMD_SUB);
    if (sa != sb) begin
      gt = sb;
    end else if (sa) begin
      gt = xm_q < ym_q;
    end else begin
      gt = xm_q > ym_q;
    end
    rn   = PW'(an_q);
    rd   = PW'(ad_q);
    rneg = sa;
    if (!is_red) begin
      case (cmd_q)
        CMD_MAX: begin
          if (!gt) begin
            rn   = PW'(bn_q);
            rd   = PW'(bd_q);
            rneg = sb;
          end
        end
        CMD_ADD, CMD_SUB: begin
          rd = PW'(pd_q);
          if (sa == yneg) begin
            rn   = PW'(xm_q) + PW'(ym_q);
            rneg = sa;
          end else if (xm_q >= ym_q) begin
            rn   = PW'(xm_q - ym_q);
            rneg = sa;
          end else begin
            rn   = PW'(ym_q - xm_q);
            rneg = yneg;
          end
          if (rn == '0) rneg = 1'b0;
        end
        CMD_MUL: begin
          rn   = PW'(pn_q);
          rd   = PW'(pd_q);
          rneg = (sa != sb) && (pn_q != '0);
        end
        default: begin
          rn   = PW'(xm_q);
          rd   = PW'(ym_q);
          rneg = (sa != sb) && (xm_q != '0);
        end
      endcase
    end
  end

  assign ext_n = XW'(qn);
  assign ext_d = XW'(qd);

  rau_iter #(
    .PW(PW)
  ) u_iter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (iter_go),
    .n_i     (rn),
    .d_i     (rd),
    .done_o  (iter_done),
    .qn_o    (qn),
    .qd_o    (qd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
      an_q  <= mag(a_num_i);
      ad_q  <= mag(a_den_i);
      bn_q  <= mag(b_num_i);
      bd_q  <= mag(b_den_i);
      ans_q <= a_num_i[W-1];
      ads_q <= a_den_i[W-1];
      bns_q <= b_num_i[W-1];
      bds_q <= b_den_i[W-1];
    end
    case (state_q)
      S_MUL0: xm_q <= prod;
      S_MUL1: ym_q <= prod;
      S_MUL2: pd_q <= prod;
      S_MUL3: pn_q <= prod;
      S_PREP: begin
        neg_q <= rneg;
        if (err) begin
          res_num_q <= '0;
          res_den_q <= '0;
          err_q     <= 1'b1;
        end else if (rn == '0) begin
          res_num_q <= '0;
          res_den_q <= DEN_W'(1);
          err_q     <= 1'b0;
        end
      end
      S_WAIT: begin
        if (iter_done) begin
          res_num_q <= neg_q ? NUM_W'(~ext_n + 1'b1) : NUM_W'(ext_n);
          res_den_q <= DEN_W'(ext_d);
          err_q     <= 1'b0;
        end
      end
      default: begin
        neg_q <= neg_q;
      end
    endcase
  end

  assign res_num_o        = res_num_q;
  assign res_den_o        = res_den_q;
  assign zero_den_error_o = err_q;

  a_valid_then_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !busy_o) else $error("busy after result");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !valid_o)) else $error("start not taken");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && zero_den_error_o) |-> (res_num_o == '0 && res_den_o == '0))
    else $error("error result not zero");
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy_o) else $error("result while idle");

endmodule

/* sim/rau_checker.sv */
`timescale 1ns / 1ps
module rau_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              busy_o,
  input  logic [rau_pkg::CMD_W-1:0]         cmd_i,
  input  logic signed [15:0]                a_num_i,
  input  logic signed [15:0]                a_den_i,
  input  logic signed [15:0]                b_num_i,
  input  logic signed [15:0]                b_den_i,
  input  logic                              valid_o,
  input  logic signed [rau_pkg::NUM_W-1:0]  res_num_o,
  input  logic [rau_pkg::DEN_W-1:0]         res_den_o,
  input  logic                              zero_den_error_o,
  output int                                fail_count,
  output int                                pending
);
  import rau_pkg::*;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic             err;
  } frac_word_t;

  frac_word_t expected_q[$];

  assign pending = expected_q.size();

  function automatic longint unsigned magnitude(logic signed [15:0] v);
    longint signed s;
    s = v;
    return (s < 0) ? longint'(-s) : longint'(s);
  endfunction

  function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic frac_word_t lowest_terms(bit neg, longint unsigned n, longint unsigned d,
                                              bit err);
    frac_word_t w;
    longint unsigned g;
    longint unsigned nn;
    w = '0;
    if (err || d == 0) begin
      w.err = 1'b1;
    end else if (n == 0) begin
      w.den = DEN_W'(1);
    end else begin
      g = gcd64(n, d);
      nn = n / g;
      w.num = NUM_W'(neg ? (64'd0 - nn) : nn);
      w.den = DEN_W'(d / g);
    end
    return w;
  endfunction

  function automatic frac_word_t predict_fraction(logic [2:0] op, logic signed [15:0] an,
                                                  logic signed [15:0] ad,
                                                  logic signed [15:0] bn,
                                                  logic signed [15:0] bd);
    longint unsigned anm, adm, bnm, bdm, xm, ym, sm;
    bit aneg, bneg, xn, yn, sn, gt;
    anm = magnitude(an); adm = magnitude(ad);
    bnm = magnitude(bn); bdm = magnitude(bd);
    aneg = (an[15] != ad[15]) && anm != 0;
    bneg = (bn[15] != bd[15]) && bnm != 0;
    if (!(op inside {CMD_MAX, CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV}))
      return lowest_terms(aneg, anm, adm, adm == 0);
    if (adm == 0 || bdm == 0) return lowest_terms(0, 0, 0, 1);
    xn = aneg; xm = anm * bdm;
    yn = bneg; ym = bnm * adm;
    case (op)
      CMD_MAX: begin
        if (xm == 0) xn = 0;
        if (ym == 0) yn = 0;
        if (xn != yn) gt = yn;
        else if (xn) gt = xm < ym;
        else gt = xm > ym;
        return gt ? lowest_terms(aneg, anm, adm, 0) : lowest_terms(bneg, bnm, bdm, 0);
      end
      CMD_ADD, CMD_SUB: begin
        if (op == CMD_SUB) yn = !yn;
        if (xn == yn) begin
          sn = xn; sm = xm + ym;
        end else if (xm >= ym) begin
          sn = xn; sm = xm - ym;
        end else begin
          sn = yn; sm = ym - xm;
        end
        if (sm == 0) sn = 0;
        return lowest_terms(sn, sm, adm * bdm, 0);
      end
      CMD_MUL: return lowest_terms(aneg != bneg, anm * bnm, adm * bdm, 0);
      default: begin
        if (bnm == 0) return lowest_terms(0, 0, 0, 1);
        return lowest_terms(aneg != bneg, anm * bdm, bnm * adm, 0);
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk_i) begin
    frac_word_t w;
    if (rst_ni) begin
      if (valid_o) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          w = expected_q.pop_front();
          if (res_num_o !== $signed(w.num))
            report_mismatch("res_num", res_num_o, $signed(w.num));
          if (res_den_o !== w.den) report_mismatch("res_den", res_den_o, w.den);
          if (zero_den_error_o !== w.err)
            report_mismatch("zero_den_error", zero_den_error_o, w.err);
        end
      end
      if (start_i && !busy_o)
        expected_q.push_back(predict_fraction(cmd_i, a_num_i, a_den_i, b_num_i, b_den_i));
    end
  end
endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
module tb;
  import rau_pkg::*;

  logic clk_i, rst_ni, start_i, busy_o, valid_o, zero_den_error_o;
  logic [CMD_W-1:0] cmd_i;
  logic signed [15:0] a_num_i, a_den_i, b_num_i, b_den_i;
  logic signed [NUM_W-1:0] res_num_o;
  logic [DEN_W-1:0] res_den_o;
  int fail_count, pending, cycles, idle_pct;

  rational_arithmetic_unit uut (.*);
  rau_checker chk (.*);

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 0;
      3: return $urandom_range(0, 1) ? 16'sd1 : -16'sd1;
      4, 5: return $signed(16'($urandom_range(0, 24))) - 16'sd12;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_word(logic [2:0] op, logic signed [15:0] an, logic signed [15:0] ad,
                           logic signed [15:0] bn, logic signed [15:0] bd);
    while ($urandom_range(0, 99) < idle_pct) @(negedge clk_i);
    cmd_i = op; a_num_i = an; a_den_i = ad; b_num_i = bn; b_den_i = bd;
    start_i = 1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
    start_i = 0;
  endtask

  task automatic send_random();
    logic signed [15:0] bd;
    bd = pick_value();
    if (bd == 0 && $urandom_range(0, 3) != 0) bd = 16'sd7;
    send_word(3'($urandom_range(0, 7)), pick_value(), pick_value(), pick_value(), bd);
  endtask

  initial begin
    cycles = 0; idle_pct = 0;
    start_i = 0; cmd_i = 0; a_num_i = 0; a_den_i = 1; b_num_i = 0; b_den_i = 1;
    rst_ni = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    send_word(CMD_REDUCE, 16'sh8000, 16'sh8000, 0, 1);
    send_word(CMD_REDUCE, 16'sh7fff, 16'sh8000, 0, 1);
    send_word(CMD_REDUCE, 6, -4, 0, 1);
    send_word(CMD_REDUCE, 0, -5, 0, 1);
    send_word(CMD_REDUCE, 3, 0, 1, 1);
    send_word(3'd6, -9, 12, 1, 0);
    send_word(3'd7, 16'sh7fff, 16'sh7fff, 0, 0);
    send_word(CMD_MAX, 1, 2, 2, 4);
    send_word(CMD_MAX, -1, 3, 1, -2);
    send_word(CMD_MAX, 16'sh8000, 1, 16'sh7fff, 1);
    send_word(CMD_MAX, 1, 1, 1, 0);
    send_word(CMD_ADD, 16'sh7fff, 1, 16'sh7fff, 1);
    send_word(CMD_ADD, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
    send_word(CMD_ADD, 1, 3, -1, 3);
    send_word(CMD_SUB, 16'sh8000, 1, 16'sh7fff, 1);
    send_word(CMD_SUB, 1, 0, 1, 1);
    send_word(CMD_MUL, 16'sh8000, 1, 16'sh8000, 1);
    send_word(CMD_MUL, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
    send_word(CMD_MUL, 0, -3, 5, 7);
    send_word(CMD_DIV, 3, 4, 0, 5);
    send_word(CMD_DIV, 16'sh8000, 1, 1, 16'sh8000);
    send_word(CMD_DIV, -2, 3, -4, 9);
    for (int p = 0; p < 4; p++) begin
      idle_pct = (p == 1 || p == 2) ? 58 : (p == 3 ? 16 : 0);
      for (int i = 0; i < 490; i++) send_random();
    end
    while (pending != 0 || busy_o) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

/* rational_arithmetic_unit.f */
src/rau_pkg.sv
src/rau_iter.sv
src/rational_arithmetic_unit.sv
sim/rau_checker.sv
sim/tb.sv
